// ===== rtl/bbc_pkg.sv =====
// Shared types and constants for the bracket balance checker.
package bbc_pkg;

    // Character codes
    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] CHR_PAREN_OPEN  = 8'h28;
    localparam logic [7:0] CHR_PAREN_CLOSE = 8'h29;
    localparam logic [7:0] CHR_SQUARE_OPEN  = 8'h5B;
    localparam logic [7:0] CHR_SQUARE_CLOSE = 8'h5D;
    localparam logic [7:0] CHR_CURLY_OPEN  = 8'h7B;
    localparam logic [7:0] CHR_CURLY_CLOSE = 8'h7D;

    // Bracket kinds held on the stack
    localparam logic [1:0] KIND_PAREN  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;

    // Mode register values
    localparam logic MODE_PAREN_ONLY = 1'b0;
    localparam logic MODE_MULTI_KIND = 1'b1;

    // Register map (word index)
    localparam logic REG_BRACKET_MODE = 1'b0;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_MISMATCH = 3'd1,
        ERR_EMPTY    = 3'd2,
        ERR_UNCLOSED = 3'd3,
        ERR_OVERFLOW = 3'd4
    } err_kind_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic       balanced;
        logic [2:0] error_kind;
    } out_item_t;

    // Shift command for the row of stack cells
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [1:0] kind;
    } stack_op_t;

endpackage

// ===== rtl/bbc_cell.sv =====
// One stack entry: takes its upper neighbor on push, its lower neighbor on pop.
module bbc_cell (
    input  logic                aclk,
    input  bbc_pkg::stack_op_t  op,
    input  logic [1:0]          upper_kind,
    input  logic [1:0]          lower_kind,
    output logic [1:0]          kind
);

    logic [1:0] kind_reg;

    // Shift down on push, up on pop, else hold
    always_ff @(posedge aclk) begin
        if (op.push) begin
            kind_reg <= upper_kind;
        end else if (op.pop) begin
            kind_reg <= lower_kind;
        end
    end

    assign kind = kind_reg;

endmodule

// ===== rtl/bbc_cell_row.sv =====
// Row of stack cells; cell 0 holds the top of the stack.
module bbc_cell_row #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                aclk,
    input  bbc_pkg::stack_op_t  op,
    output logic [1:0]          top_kind
);

    logic [1:0] kinds [STACK_DEPTH];

    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++) begin : g_cell
            logic [1:0] upper_kind;
            logic [1:0] lower_kind;

            // New entry enters at the top; bottom cell holds its own on pop
            if (i == 0) begin : g_top
                assign upper_kind = op.kind;
            end else begin : g_mid
                assign upper_kind = kinds[i-1];
            end
            if (i == STACK_DEPTH - 1) begin : g_bot
                assign lower_kind = kinds[i];
            end else begin : g_low
                assign lower_kind = kinds[i+1];
            end

            bbc_cell u_cell (
                .aclk       (aclk),
                .op         (op),
                .upper_kind (upper_kind),
                .lower_kind (lower_kind),
                .kind       (kinds[i])
            );
        end
    endgenerate

    assign top_kind = kinds[0];

endmodule

// ===== rtl/bracket_balance_checker_core.sv =====
// Result: the verdict is on m_valid in the cycle after the item with last_char is accepted.
// Throughput: one item per cycle while the output register is free or draining; each item
// does at most one push or pop, and the cell row shifts one place per cycle.
// Reset: level, latched error, end flag and output valid clear; bracket_mode
// returns to 1 (multi-kind); stack cells are not cleared and are read only below the level.
// Top level of the bracket balance checker.
module bracket_balance_checker_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Input items
    input  logic               s_valid,
    output logic               s_ready,
    input  bbc_pkg::in_item_t  s_item,
    // Result items
    output logic               m_valid,
    input  logic               m_ready,
    output bbc_pkg::out_item_t m_item,
    // Configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);

    logic                mode_reg;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    bbc_pkg::err_kind_t  err_reg, err_next, fin_err;
    logic                ended_reg, ended_next;
    logic                m_valid_reg, m_valid_next;
    bbc_pkg::out_item_t  m_item_reg, m_item_next;
    bbc_pkg::stack_op_t  op;
    logic [1:0]          top_kind;
    logic                take;
    logic                active;
    logic                full;
    logic                is_open, is_close;
    logic [1:0]          chr_kind;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == bbc_pkg::REG_BRACKET_MODE) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= bbc_pkg::MODE_MULTI_KIND;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == bbc_pkg::REG_BRACKET_MODE) begin
            mode_reg <= pwdata[0];
        end
    end

    // Accept while the output register is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign active  = !ended_reg && (err_reg == bbc_pkg::ERR_NONE);
    assign full    = (lvl_reg == LVL_FULL);

    // Classify the byte
    always_comb begin
        is_open  = 1'b0;
        is_close = 1'b0;
        chr_kind = bbc_pkg::KIND_PAREN;
        case (s_item.char_byte)
            bbc_pkg::CHR_PAREN_OPEN: begin
                is_open = 1'b1;
            end
            bbc_pkg::CHR_SQUARE_OPEN: begin
                is_open  = 1'b1;
                chr_kind = bbc_pkg::KIND_SQUARE;
            end
            bbc_pkg::CHR_CURLY_OPEN: begin
                is_open  = 1'b1;
                chr_kind = bbc_pkg::KIND_CURLY;
            end
            bbc_pkg::CHR_PAREN_CLOSE: begin
                is_close = 1'b1;
            end
            bbc_pkg::CHR_SQUARE_CLOSE: begin
                is_close = 1'b1;
                chr_kind = bbc_pkg::KIND_SQUARE;
            end
            bbc_pkg::CHR_CURLY_CLOSE: begin
                is_close = 1'b1;
                chr_kind = bbc_pkg::KIND_CURLY;
            end
            default: begin
            end
        endcase
    end

    // Stack control, error latch and verdict
    always_comb begin
        op           = '0;
        op.kind      = chr_kind;
        lvl_next     = lvl_reg;
        err_next     = err_reg;
        ended_next   = ended_reg;
        fin_err      = bbc_pkg::ERR_NONE;
        m_item_next  = m_item_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;

        if (take) begin
            if (active) begin
                if (s_item.char_byte == bbc_pkg::CHR_NUL) begin
                    ended_next = 1'b1;
                end else if (mode_reg == bbc_pkg::MODE_PAREN_ONLY) begin
                    if (s_item.char_byte == bbc_pkg::CHR_PAREN_OPEN) begin
                        if (full) begin
                            err_next = bbc_pkg::ERR_OVERFLOW;
                        end else begin
                            op.push  = 1'b1;
                            lvl_next = lvl_reg + 1'b1;
                        end
                    end else if (s_item.char_byte == bbc_pkg::CHR_PAREN_CLOSE &&
                                 lvl_reg != '0) begin
                        op.pop   = 1'b1;
                        lvl_next = lvl_reg - 1'b1;
                    end
                end else if (is_open) begin
                    if (full) begin
                        err_next = bbc_pkg::ERR_OVERFLOW;
                    end else begin
                        op.push  = 1'b1;
                        lvl_next = lvl_reg + 1'b1;
                    end
                end else if (is_close) begin
                    if (lvl_reg == '0) begin
                        err_next = bbc_pkg::ERR_EMPTY;
                    end else if (top_kind != chr_kind) begin
                        err_next = bbc_pkg::ERR_MISMATCH;
                    end else begin
                        op.pop   = 1'b1;
                        lvl_next = lvl_reg - 1'b1;
                    end
                end
            end

            if (s_item.last_char) begin
                fin_err = err_next;
                if (fin_err == bbc_pkg::ERR_NONE && lvl_next != '0) begin
                    fin_err = bbc_pkg::ERR_UNCLOSED;
                end
                m_item_next.balanced   = (fin_err == bbc_pkg::ERR_NONE);
                m_item_next.error_kind = fin_err;
                m_valid_next = 1'b1;
                lvl_next     = '0;
                err_next     = bbc_pkg::ERR_NONE;
                ended_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_reg     <= '0;
            err_reg     <= bbc_pkg::ERR_NONE;
            ended_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            lvl_reg     <= lvl_next;
            err_reg     <= err_next;
            ended_reg   <= ended_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    bbc_cell_row #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_row (
        .aclk     (aclk),
        .op       (op),
        .top_kind (top_kind)
    );

endmodule

// ===== rtl/bbc_checker.sv =====
// Port-level checks for the bracket balance checker, bound to the top level.
module bbc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input bbc_pkg::out_item_t m_item
);

    // No result item right after reset
    a_idle_after_reset: assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // Verdict flag agrees with the error code
    a_balanced_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.balanced == (m_item.error_kind == bbc_pkg::ERR_NONE)))
        else $error("balanced flag disagrees with error_kind");

    // Error code stays in its range
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.error_kind <= bbc_pkg::ERR_OVERFLOW))
        else $error("error_kind out of range");

    // Empty output stage is always ready for an item
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result pending");

    // Stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item)))
        else $error("stalled result item changed");

endmodule

bind bracket_balance_checker_core bbc_checker u_bbc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
